// ===== rtl/core/binary_entropy_accumulator_defines.svh =====
// Assertion helpers shared by the RTL.
// Both expect a clock named clock and a synchronous reset named reset in scope.
`ifndef BINARY_ENTROPY_ACCUMULATOR_DEFINES_SVH
`define BINARY_ENTROPY_ACCUMULATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BEA_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bea assertion failed");

// Consequent checked in the cycle after the antecedent.
`define BEA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bea assertion failed");

`endif

// ===== rtl/core/bea_pkg.sv =====
`default_nettype none
package bea_pkg;

   localparam int MAX_ITEMS      = 65536;
   localparam int LOG_TABLE_BITS = 8;

   localparam int PROB_W  = 17;
   localparam int SUM_W   = 32;
   localparam int COUNT_W = 17;
   localparam int FRAC_W  = 16;

   localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(1 << FRAC_W);

   // item count saturates here; further items are dropped
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (MAX_ITEMS > ((1 << COUNT_W) - 1)) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_ITEMS);

   // log2 table geometry
   localparam int R_W        = FRAC_W - LOG_TABLE_BITS;
   localparam int KNOT_COUNT = (1 << LOG_TABLE_BITS) + 1;
   localparam int KNOT_W     = FRAC_W + 1;
   localparam int KIDX_W     = LOG_TABLE_BITS + 1;
   localparam int EXP_W      = 4;
   localparam int INTERP_W   = KNOT_W + R_W;

   // log2(v) in Q.16 stays below 16.0; 16.0 itself needs LOG_W bits
   localparam int LOG_W  = FRAC_W + EXP_W + 1;
   localparam int PROD_W = FRAC_W + LOG_W;
   localparam int TERM_W = LOG_W;
   localparam int H_W    = TERM_W + 1;

   typedef logic [KNOT_W-1:0] knot_table_type [KNOT_COUNT];

   // knot k = log2(1 + k/2^B) in Q1.16, by repeated squaring
   function automatic knot_table_type build_knots();
      knot_table_type    tbl;
      logic [63:0]       x;
      logic [KNOT_W-1:0] res;
      for (int k = 0; k < KNOT_COUNT; k++) begin
         x = 64'(64'((1 << LOG_TABLE_BITS) + k) << (30 - LOG_TABLE_BITS));
         if (x >= 64'h8000_0000) begin
            res = ONE_Q16;
         end else begin
            res = '0;
            for (int n = 0; n < FRAC_W; n++) begin
               x   = (x * x) >> 30;
               res = {res[KNOT_W-2:0], 1'b0};
               if (x >= 64'h8000_0000) begin
                  x      = x >> 1;
                  res[0] = 1'b1;
               end
            end
         end
         tbl[k] = res;
      end
      return tbl;
   endfunction

   localparam knot_table_type KNOT_TABLE = build_knots();

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOG_P,
      ST_MUL_P,
      ST_LOG_Q,
      ST_MUL_Q,
      ST_ACC
   } state_type;

   typedef struct packed {
      logic take_item;  // latch incoming probability
      logic log_en;     // table lookup + interpolation product
      logic mul_en;     // term multiply
      logic use_comp;   // operate on 1-p instead of p
      logic acc_en;     // add entropy into the running sum
   } cmd_type;

   typedef struct packed {
      logic last;       // held item carries the last mark
      logic out_free;   // output register can take a result this cycle
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/core/bea_ctrl.sv =====
`default_nettype none
module bea_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire bea_pkg::status_type status,
   output bea_pkg::cmd_type         cmd
);

   bea_pkg::state_type state_ff;
   bea_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bea_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         bea_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = bea_pkg::ST_LOG_P;
            end
         end
         bea_pkg::ST_LOG_P: begin
            cmd.log_en = 1'b1;
            state_in   = bea_pkg::ST_MUL_P;
         end
         bea_pkg::ST_MUL_P: begin
            cmd.mul_en = 1'b1;
            state_in   = bea_pkg::ST_LOG_Q;
         end
         bea_pkg::ST_LOG_Q: begin
            cmd.log_en   = 1'b1;
            cmd.use_comp = 1'b1;
            state_in     = bea_pkg::ST_MUL_Q;
         end
         bea_pkg::ST_MUL_Q: begin
            cmd.mul_en   = 1'b1;
            cmd.use_comp = 1'b1;
            state_in     = bea_pkg::ST_ACC;
         end
         bea_pkg::ST_ACC: begin
            // a last item waits here until the output register drains
            if (!status.last || status.out_free) begin
               cmd.acc_en = 1'b1;
               state_in   = bea_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bea_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/bea_datapath.sv =====
`default_nettype none
`include "binary_entropy_accumulator_defines.svh"
module bea_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bea_pkg::cmd_type              cmd,
   output bea_pkg::status_type                status,
   input  wire logic [bea_pkg::PROB_W-1:0]    req_prob,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [bea_pkg::SUM_W-1:0]          rsp_entropy_total,
   output logic [bea_pkg::COUNT_W-1:0]        rsp_items_summed
);

   localparam int PW = bea_pkg::PROB_W;
   localparam int FW = bea_pkg::FRAC_W;
   localparam int RW = bea_pkg::R_W;
   localparam int LW = bea_pkg::LOG_W;
   localparam int SW = bea_pkg::SUM_W;
   localparam int CW = bea_pkg::COUNT_W;

   // held item
   logic [PW-1:0] prob_ff, prob_in;
   logic          last_ff;

   // log stage registers
   logic [bea_pkg::EXP_W-1:0]    exp_ff, exp_in;
   logic [bea_pkg::KNOT_W-1:0]   k0_ff, k0_in;
   logic [bea_pkg::INTERP_W-1:0] interp_ff, interp_in;

   // term registers
   logic [bea_pkg::TERM_W-1:0] term_p_ff, term_q_ff, term_in;

   // running state and output register
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] rsp_sum_ff;
   logic [CW-1:0] rsp_count_ff;
   logic          rsp_valid_ff;

   logic [PW-1:0]                 operand;
   logic                          term_zero;
   logic [2*FW-1:0]               shifted;
   logic [FW-1:0]                 mant;
   logic [bea_pkg::KIDX_W-1:0]    idx_lo, idx_hi;
   logic [RW-1:0]                 frac_r;
   logic [bea_pkg::KNOT_W-1:0]    k1, k_diff;
   logic [LW-1:0]                 log_val, log_rem;
   logic [bea_pkg::PROD_W-1:0]    prod;
   logic [bea_pkg::H_W-1:0]       h_sum;
   logic [SW:0]                   sum_wide;

   assign prob_in = (req_prob > bea_pkg::ONE_Q16) ? bea_pkg::ONE_Q16 : req_prob;

   assign operand   = cmd.use_comp ? (bea_pkg::ONE_Q16 - prob_ff) : prob_ff;
   assign term_zero = (operand == '0) || operand[PW-1];

   // leading-one position of the operand
   always_comb begin
      exp_in = '0;
      for (int i = 0; i < FW; i++) begin
         if (operand[i]) begin
            exp_in = bea_pkg::EXP_W'(i);
         end
      end
   end

   // normalize, drop the implicit one, split into index and remainder
   assign shifted   = {{FW{1'b0}}, operand[FW-1:0]} << (5'd16 - {1'b0, exp_in});
   assign mant      = shifted[FW-1:0];
   assign idx_lo    = {1'b0, mant[FW-1:RW]};
   assign idx_hi    = idx_lo + 1'b1;
   assign frac_r    = mant[RW-1:0];
   assign k0_in     = bea_pkg::KNOT_TABLE[idx_lo];
   assign k1        = bea_pkg::KNOT_TABLE[idx_hi];
   assign k_diff    = k1 - k0_in;
   assign interp_in = bea_pkg::INTERP_W'(k_diff) * bea_pkg::INTERP_W'(frac_r);

   // term = v * (16 - log2 v), Q5.16
   assign log_val = (LW'(exp_ff) << FW) + LW'(k0_ff) + LW'(interp_ff >> RW);
   assign log_rem = LW'(16 << FW) - log_val;
   assign prod    = bea_pkg::PROD_W'(operand[FW-1:0]) * bea_pkg::PROD_W'(log_rem);
   assign term_in = term_zero ? '0 : bea_pkg::TERM_W'(prod >> FW);

   // saturating accumulate, item count capped
   assign h_sum    = bea_pkg::H_W'(term_p_ff) + bea_pkg::H_W'(term_q_ff);
   assign sum_wide = {1'b0, sum_ff} + (SW + 1)'(h_sum);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (count_ff < bea_pkg::COUNT_CAP) begin
         sum_in   = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         prob_ff <= prob_in;
         last_ff <= req_last;
      end
      if (cmd.log_en) begin
         exp_ff    <= exp_in;
         k0_ff     <= k0_in;
         interp_ff <= interp_in;
      end
      if (cmd.mul_en && !cmd.use_comp) begin
         term_p_ff <= term_in;
      end
      if (cmd.mul_en && cmd.use_comp) begin
         term_q_ff <= term_in;
      end
      if (cmd.acc_en && last_ff) begin
         rsp_sum_ff   <= sum_in;
         rsp_count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.acc_en) begin
            sum_ff   <= last_ff ? '0 : sum_in;
            count_ff <= last_ff ? '0 : count_in;
         end
         if (cmd.acc_en && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entropy_total = rsp_sum_ff;
   assign rsp_items_summed  = rsp_count_ff;

   `BEA_ASSERT_SAME(a_count_capped, cmd.acc_en, count_ff <= bea_pkg::COUNT_CAP)
   `BEA_ASSERT_NEXT(a_clear_on_last, cmd.acc_en && last_ff, (count_ff == '0) && (sum_ff == '0))
   `BEA_ASSERT_SAME(a_mul_after_log, cmd.mul_en, $past(cmd.log_en))

endmodule
`default_nettype wire

// ===== rtl/core/binary_entropy_accumulator.sv =====
// Binary entropy accumulator. Each accepted probability p (unsigned Q0.16,
// 65536 = 1.0, larger values clamped to 1.0) adds H(p) = -p*log2(p) -
// (1-p)*log2(1-p) into a saturating Q16.16 running sum, with 0*log2(0)
// taken as zero. log2 comes from a constant table of 257 knots with linear
// interpolation. Item counting stops at the cap (65536 items); items past
// the cap add nothing. An item with req_last high produces one transfer on
// the rsp_ channel carrying the total and the item count, and clears both.
// Timing: the block works on one item at a time. It accepts the item,
// then performs a lookup/interpolate step and a multiply step for p and
// again for 1-p on the single shared term datapath, and then one
// accumulate step. A last item also waits in the accumulate step while the
// previous result still sits unaccepted in the output register; otherwise
// an item is accepted while a result is pending.
`default_nettype none
module binary_entropy_accumulator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [bea_pkg::PROB_W-1:0]    req_prob,
   input  wire logic                          req_last,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [bea_pkg::SUM_W-1:0]          rsp_entropy_total,
   output logic [bea_pkg::COUNT_W-1:0]        rsp_items_summed
);

   bea_pkg::cmd_type    cmd;
   bea_pkg::status_type status;

   // sequencer: steps each item through lookup, multiply and accumulate
   bea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // log2 table, term multiplier, running sum and output register
   bea_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_prob          (req_prob),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_entropy_total (rsp_entropy_total),
      .rsp_items_summed  (rsp_items_summed)
   );

endmodule
`default_nettype wire
